// ===== src/uptt_pkg.sv =====
// Package for the updatable priority task table.
// Holds field widths, command codes and the structs shared by the cell row and the top level.
// No dependencies.
package uptt_pkg;

  // Number of task slots in the table (one cell per slot).
  localparam int TASKS  = 256;
  localparam int SLOT_W = (TASKS > 1) ? $clog2(TASKS) : 1;

  // Fixed field widths.
  localparam int KIND_W = 2;
  localparam int ID_W   = 8;
  localparam int USER_W = 16;
  localparam int PRI_W  = 30;

  // Width used to compare a task id against a slot number.
  localparam int CMP_W  = (SLOT_W > ID_W) ? SLOT_W : ID_W;

  // Command codes.
  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EDIT   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_EXEC   = 2'd3;

  // Write command broadcast to every cell.
  typedef struct packed {
    logic              add;
    logic              edit;
    logic              remove;
    logic              clr;
    logic [ID_W-1:0]   task_id;
    logic [SLOT_W-1:0] clr_slot;
    logic [USER_W-1:0] user;
    logic [PRI_W-1:0]  pri;
  } cmd_t;

  // Running best candidate handed from cell to cell during a search.
  typedef struct packed {
    logic              valid;
    logic              have;
    logic [PRI_W-1:0]  pri;
    logic [USER_W-1:0] owner;
    logic [SLOT_W-1:0] slot;
  } token_t;

endpackage

// ===== src/uptt_cell.sv =====
// One slot of the task table: live mark, owner, priority, and one stage of the search chain.
// Depends on uptt_pkg.
module uptt_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [uptt_pkg::SLOT_W-1:0] slot_id,
  input  uptt_pkg::cmd_t         cmd,
  input  uptt_pkg::token_t       tok_in,
  output uptt_pkg::token_t       tok_out
);
  import uptt_pkg::*;

  logic              live_r, live_nxt;
  logic [USER_W-1:0] owner_r;
  logic [PRI_W-1:0]  pri_r;
  token_t            tok_r, tok_nxt;
  logic              id_hit, clr_hit, take;

  assign id_hit  = (CMP_W'(cmd.task_id) == CMP_W'(slot_id));
  assign clr_hit = cmd.clr && (cmd.clr_slot == slot_id);

  always_comb begin
    live_nxt = live_r;
    if (cmd.add && id_hit) begin
      live_nxt = 1'b1;
    end else if ((cmd.remove && id_hit) || clr_hit) begin
      live_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= 1'b0;
    end else begin
      live_r <= live_nxt;
    end
  end

  // Owner and priority need no reset; they are read only while the slot is live.
  always_ff @(posedge clk) begin
    if (cmd.add && id_hit) begin
      owner_r <= cmd.user;
      pri_r   <= cmd.pri;
    end else if (cmd.edit && id_hit && live_r) begin
      pri_r   <= cmd.pri;
    end
  end

  // Slots are visited in ascending order, so >= hands ties to the larger id.
  assign take = tok_in.valid && live_r && (!tok_in.have || (pri_r >= tok_in.pri));

  always_comb begin
    tok_nxt = tok_in;
    if (take) begin
      tok_nxt.have  = 1'b1;
      tok_nxt.pri   = pri_r;
      tok_nxt.owner = owner_r;
      tok_nxt.slot  = slot_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

// ===== src/updatable_priority_task_table.sv =====
// Top level of the updatable priority task table: command decode, search control, result register.
// Depends on uptt_pkg and uptt_cell.
//
//   Channel   Direction  Handshake             Payload
//   in_       in         in_valid / in_stall   in_kind, in_task_id, in_user_id, in_priority_req
//   out_      out        out_valid / out_stall out_found, out_owner
//
// Add, edit and remove are broadcast to every cell, and the addressed cell updates itself
// at the accepting edge.
// Execute-top: a search token walks the row of cells one cell per cycle, the winner is captured
// as the token leaves the end of the row, and then, once the result register is free, the
// result register is loaded and the winning slot is cleared.
// rst_n is synchronous and active low; it clears all live marks and the control state at once.
// in_stall is high during a search and while a search result waits for the result register.
// A result held by out_stall does not block add, edit or remove transactions.
module updatable_priority_task_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [uptt_pkg::KIND_W-1:0]   in_kind,
  input  logic [uptt_pkg::ID_W-1:0]     in_task_id,
  input  logic [uptt_pkg::USER_W-1:0]   in_user_id,
  input  logic [uptt_pkg::PRI_W-1:0]    in_priority_req,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_found,
  output logic [uptt_pkg::USER_W-1:0]   out_owner
);
  import uptt_pkg::*;

  // Control states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t            state_r, state_nxt;

  // Search result captured at the end of the row.
  logic              res_have_r;
  logic [USER_W-1:0] res_owner_r;
  logic [SLOT_W-1:0] res_slot_r;

  // Result register toward the output channel.
  logic              out_valid_r;
  logic              out_found_r;
  logic [USER_W-1:0] out_owner_r;

  logic              in_acc;
  logic              start_exec;
  logic              out_free;
  logic              load_out;
  cmd_t              cmd;
  token_t            tok [TASKS+1];
  logic [TASKS-1:0]  tok_vld;

  // A new transaction is taken only when no search is in flight.
  assign in_stall   = (state_r != ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign start_exec = in_acc && (in_kind == KIND_EXEC);

  // The result register can take a new value when it is empty or being drained.
  assign out_free = !out_valid_r || !out_stall;
  assign load_out = (state_r == ST_DONE) && out_free;

  // Command broadcast. The clear of the winning slot rides the same bus as the loading
  // of the result, which only happens while no input transaction can be accepted.
  always_comb begin
    cmd          = '0;
    cmd.task_id  = in_task_id;
    cmd.user     = in_user_id;
    cmd.pri      = in_priority_req;
    cmd.clr_slot = res_slot_r;
    cmd.add      = in_acc && (in_kind == KIND_ADD);
    cmd.edit     = in_acc && (in_kind == KIND_EDIT);
    cmd.remove   = in_acc && (in_kind == KIND_REMOVE);
    cmd.clr      = load_out && res_have_r;
  end

  // A search starts with an empty candidate entering the first cell.
  always_comb begin
    tok[0]       = '0;
    tok[0].valid = start_exec;
  end

  for (genvar i = 0; i < TASKS; i++) begin : g_cell
    uptt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .slot_id (SLOT_W'(i)),
      .cmd     (cmd),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
    assign tok_vld[i] = tok[i+1].valid;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start_exec) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tok[TASKS].valid) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capture the winner as the token leaves the last cell.
  always_ff @(posedge clk) begin
    if (tok[TASKS].valid) begin
      res_have_r  <= tok[TASKS].have;
      res_owner_r <= tok[TASKS].have ? tok[TASKS].owner : '0;
      res_slot_r  <= tok[TASKS].slot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_found_r <= res_have_r;
      out_owner_r <= res_owner_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_found = out_found_r;
  assign out_owner = out_owner_r;

  // At most one search token travels along the row.
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vld))
    else $error("more than one search token in the cell row");

  // No token is in the row while the block is idle.
  a_idle_no_token: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (tok_vld == '0))
    else $error("search token present while idle");

  // Finishing a search always presents a result on the next cycle.
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r)
    else $error("search finished without a result");

  // A not-found result carries a zero owner.
  a_zero_owner: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_owner_r == '0))
    else $error("not-found result with nonzero owner");

endmodule

// ===== tb/tb_updatable_priority_task_table.sv =====
`timescale 1ns / 1ps
// Testbench for the updatable priority task table. It sends directed and random commands and
// predicts every execute-top result with a scoreboard class kept in step with the commands.
// Depends on uptt_pkg and updatable_priority_task_table.
module tb_updatable_priority_task_table;
  import uptt_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int CYCLE_LIMIT  = 3000000;
  localparam int PHASE_ITEMS  = 425;
  localparam int DRAIN_CYCLES = TASKS + 8;

  localparam logic [PRI_W-1:0]  PRI_MAX  = '1;
  localparam logic [USER_W-1:0] USER_MAX = '1;
  localparam logic [ID_W-1:0]   ID_MAX   = '1;

  // One execute-top result as the block should report it.
  typedef struct {
    logic              found;
    logic [USER_W-1:0] owner;
  } exec_result_t;

  // The scoreboard mirrors the task table. Every accepted command updates the mirror, and every
  // execute-top transaction queues the result that the block owes us.
  class exec_scoreboard;
    logic              live_tab  [TASKS];
    logic [USER_W-1:0] owner_tab [TASKS];
    logic [PRI_W-1:0]  pri_tab   [TASKS];
    exec_result_t      pending_execs [$];
    int                fail_count;

    function new();
      foreach (live_tab[i]) begin
        live_tab[i]  = 1'b0;
        owner_tab[i] = '0;
        pri_tab[i]   = '0;
      end
      fail_count = 0;
    endfunction

    function void note_cmd(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
                           logic [USER_W-1:0] user, logic [PRI_W-1:0] pri);
      exec_result_t res;
      bit           have;
      int           best;
      have = 1'b0;
      best = 0;
      if (kind != KIND_EXEC && int'(id) >= TASKS) return;
      case (kind)
        KIND_ADD: begin
          live_tab[id]  = 1'b1;
          owner_tab[id] = user;
          pri_tab[id]   = pri;
        end
        KIND_EDIT: begin
          if (live_tab[id]) pri_tab[id] = pri;
        end
        KIND_REMOVE: begin
          live_tab[id] = 1'b0;
        end
        KIND_EXEC: begin
          // Scanning upward with >= hands ties to the larger task id.
          for (int i = 0; i < TASKS; i++) begin
            if (live_tab[i] && (!have || pri_tab[i] >= pri_tab[best])) begin
              have = 1'b1;
              best = i;
            end
          end
          res.found = have;
          res.owner = have ? owner_tab[best] : '0;
          if (have) live_tab[best] = 1'b0;
          pending_execs.push_back(res);
        end
      endcase
    endfunction

    function void check_exec(logic found, logic [USER_W-1:0] owner);
      exec_result_t want;
      if (pending_execs.size() == 0) begin
        $error("unexpected result: found %0d owner 0x%04h", found, owner);
        fail_count++;
        return;
      end
      want = pending_execs.pop_front();
      if (found !== want.found) begin
        $error("found: expected %0d, actual %0d", want.found, found);
        fail_count++;
      end
      if (owner !== want.owner) begin
        $error("owner: expected 0x%04h, actual 0x%04h", want.owner, owner);
        fail_count++;
      end
    endfunction
  endclass

  // Every input starts at a known value; the command fields hold harmless defaults until the
  // first transaction is driven.
  logic              clk             = 1'b0;
  logic              rst_n           = 1'b0;
  logic              in_valid        = 1'b0;
  logic              in_stall;
  logic [KIND_W-1:0] in_kind         = KIND_ADD;
  logic [ID_W-1:0]   in_task_id      = '0;
  logic [USER_W-1:0] in_user_id      = '0;
  logic [PRI_W-1:0]  in_priority_req = '0;
  logic              out_valid;
  logic              out_stall       = 1'b0;
  logic              out_found;
  logic [USER_W-1:0] out_owner;

  // Percentages that control how often the sender idles and the receiver stalls.
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;

  longint cycle_count;
  exec_scoreboard board;

  updatable_priority_task_table i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_task_id      (in_task_id),
    .in_user_id      (in_user_id),
    .in_priority_req (in_priority_req),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found       (out_found),
    .out_owner       (out_owner)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Result side. Signals are read right after the rising edge, before any update that the edge
  // schedules, so a transaction is seen exactly when the block sees it. The stall for the next
  // cycle is then drawn once per edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_exec(out_found, out_owner);
    out_stall <= ($urandom_range(99, 0) < receiver_stall_pct);
  end

  // Watchdog: a run that hangs on a handshake ends here as a failure.
  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  // Drives one command transaction. The sender may idle first; once valid is raised the payload
  // holds until the block takes it, and only then does the scoreboard learn of it.
  task automatic send_cmd(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                          input logic [USER_W-1:0] user, input logic [PRI_W-1:0] pri);
    while ($urandom_range(99, 0) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_task_id      <= id;
    in_user_id      <= user;
    in_priority_req <= pri;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_cmd(kind, id, user, pri);
  endtask

  // The sender holds off until every queued execute-top result has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_execs.size() != 0) @(posedge clk);
  endtask

  // A slot close to a base id, so that edits and removes often find the tasks just added.
  function automatic logic [ID_W-1:0] near_slot(int base);
    return ID_W'(base + $urandom_range(15, 0));
  endfunction

  // Narrow priorities force many ties; otherwise mostly full-width values with the extremes
  // thrown in now and then.
  function automatic logic [PRI_W-1:0] draw_priority(bit narrow);
    int pick;
    pick = $urandom_range(99, 0);
    if (narrow) return PRI_W'($urandom_range(3, 0));
    if (pick < 5) return PRI_MAX;
    if (pick < 10) return '0;
    return PRI_W'($urandom);
  endfunction

  // One phase of random traffic. Most of it is a burst that loads a few tasks around one base
  // id, edits or removes some of them, and then pulls the best ones out with execute-top. The
  // rest is noise with every field random. The loads and the pulls are about balanced, so the
  // table wanders between empty and moderately full.
  task automatic run_phase(input int items, input int idle_pct, input int stall_pct);
    int sent;
    int base;
    int n;
    bit narrow;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    sent = 0;
    while (sent < items) begin
      base   = $urandom_range(255, 0);
      narrow = 1'($urandom_range(1, 0));
      if ($urandom_range(99, 0) < 85) begin
        n = $urandom_range(10, 1);
        repeat (n) send_cmd(KIND_ADD, near_slot(base), USER_W'($urandom), draw_priority(narrow));
        sent += n;
        n = $urandom_range(5, 0);
        repeat (n) begin
          send_cmd($urandom_range(1, 0) ? KIND_EDIT : KIND_REMOVE, near_slot(base),
                   USER_W'($urandom), draw_priority(narrow));
        end
        sent += n;
        n = $urandom_range(8, 1);
        repeat (n) send_cmd(KIND_EXEC, ID_W'($urandom), USER_W'($urandom), PRI_W'($urandom));
        sent += n;
      end else begin
        n = $urandom_range(6, 1);
        repeat (n) begin
          send_cmd(KIND_W'($urandom), ID_W'($urandom), USER_W'($urandom), PRI_W'($urandom));
        end
        sent += n;
      end
    end
    wait_for_results();
  endtask

  initial begin
    board = new();

    // Synchronous reset, applied once at the start.
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, with no idling on either side.
    // An empty table answers execute-top with not-found.
    send_cmd(KIND_EXEC, ID_MAX, USER_MAX, PRI_MAX);
    // Field extremes: slot 0 with all-zero fields, slot 255 with all-ones fields, and a tie at
    // the top priority that the larger id must win.
    send_cmd(KIND_ADD, '0, '0, '0);
    send_cmd(KIND_ADD, ID_MAX, USER_MAX, PRI_MAX);
    send_cmd(KIND_ADD, 8'd128, 16'h1234, PRI_MAX);
    send_cmd(KIND_EXEC, '0, '0, '0);
    send_cmd(KIND_EXEC, '0, '0, '0);
    // Edit and remove of tasks that are not live are ignored.
    send_cmd(KIND_EDIT, 8'd7, USER_MAX, PRI_MAX);
    send_cmd(KIND_REMOVE, 8'd9, USER_MAX, PRI_MAX);
    // Re-adding a live id overwrites owner and priority; an edit then raises it into a tie
    // that it wins by id.
    send_cmd(KIND_ADD, 8'd7, 16'hAAAA, 30'd5);
    send_cmd(KIND_ADD, 8'd7, 16'h5555, 30'd3);
    send_cmd(KIND_EDIT, 8'd7, 16'hFFFF, 30'd100);
    send_cmd(KIND_ADD, 8'd3, 16'h0F0F, 30'd100);
    send_cmd(KIND_EXEC, '0, '0, '0);
    // Removing a live task takes it out of the search; the zero-priority task is found next.
    send_cmd(KIND_REMOVE, 8'd3, '0, '0);
    send_cmd(KIND_EXEC, '0, '0, '0);
    send_cmd(KIND_EXEC, '0, '0, '0);
    // Alternating bit patterns, and execute-top with junk in the fields it ignores.
    send_cmd(KIND_ADD, 8'd200, 16'h8001, 30'h2AAAAAAA);
    send_cmd(KIND_ADD, 8'd201, 16'h7FFE, 30'h15555555);
    send_cmd(KIND_EXEC, 8'hA5, 16'h5A5A, 30'h3C3C3C3C);
    send_cmd(KIND_REMOVE, 8'd201, USER_MAX, PRI_MAX);
    send_cmd(KIND_EXEC, 8'h5A, 16'hA5A5, 30'h03C3C3C3);

    // The sender pauses here until the directed results are all back.
    wait_for_results();

    // Random part in four phases: no idling, a sparse sender, a slow receiver, light idling
    // on both sides.
    run_phase(PHASE_ITEMS, 0, 0);
    run_phase(PHASE_ITEMS, 87, 0);
    run_phase(PHASE_ITEMS, 0, 87);
    run_phase(PHASE_ITEMS, 12, 12);

    // Give the block a full search time to show any stray result.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.pending_execs.size() != 0) begin
      $error("%0d execute-top results never arrived", board.pending_execs.size());
      board.fail_count++;
    end

    if (board.fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
